FILE: hdl/mec_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mec_pkg
// Shared widths, band codes and color levels for the escape-time colorer.
// ----------------------------------------------------------------------------
package mec_pkg;

	localparam int POINT_W     = 31;
	localparam int COUNT_OUT_W = 7;
	localparam int CHAN_W      = 8;
	localparam int BAND_W      = 3;
	localparam int BAND_COUNT  = 5;

	localparam logic [BAND_W-1:0] BAND_PURPLE = 3'd0;
	localparam logic [BAND_W-1:0] BAND_BLUE   = 3'd1;
	localparam logic [BAND_W-1:0] BAND_GREEN  = 3'd2;
	localparam logic [BAND_W-1:0] BAND_FADE   = 3'd3;
	localparam logic [BAND_W-1:0] BAND_RED    = 3'd4;

	localparam logic [CHAN_W-1:0] LEVEL_ZERO = 8'd0;
	localparam logic [CHAN_W-1:0] LEVEL_MID  = 8'd128;
	localparam logic [CHAN_W-1:0] LEVEL_FULL = 8'd255;
	localparam int LEVEL_STEP = 127;
	localparam int LEVEL_SPAN = 255;

	typedef struct packed {
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
	} rgb_t;

endpackage

FILE: hdl/mec_point_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mec_point_if
// Valid/ready channel carrying one complex point.
// ----------------------------------------------------------------------------
interface mec_point_if;
	logic valid;
	logic ready;
	logic signed [mec_pkg::POINT_W-1:0] point_re;
	logic signed [mec_pkg::POINT_W-1:0] point_im;

	modport source (output valid, point_re, point_im, input ready);
	modport sink (input valid, point_re, point_im, output ready);
endinterface

FILE: hdl/mec_pixel_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mec_pixel_if
// Valid/ready channel carrying the iteration count and its color.
// ----------------------------------------------------------------------------
interface mec_pixel_if;
	logic valid;
	logic ready;
	logic [mec_pkg::COUNT_OUT_W-1:0] iter_count;
	logic [mec_pkg::CHAN_W-1:0] red;
	logic [mec_pkg::CHAN_W-1:0] green;
	logic [mec_pkg::CHAN_W-1:0] blue;

	modport source (output valid, iter_count, red, green, blue, input ready);
	modport sink (input valid, iter_count, red, green, blue, output ready);
endinterface

FILE: hdl/mec_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mec_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module mec_mul #(
	parameter int W = 32
) (
	input  logic                  clk,
	input  logic signed [W-1:0]   a,
	input  logic signed [W-1:0]   b,
	output logic signed [2*W-1:0] prod
);

	logic signed [2*W-1:0] prod_q;

	always_ff @(posedge clk) begin
		prod_q <= a * b;
	end

	assign prod = prod_q;

endmodule

FILE: hdl/mec_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mec_core
// Iteration sequencer: z = z*z + c over one shared multiplier, three products
// per iteration, with the escape test and the band/offset counters.
// ----------------------------------------------------------------------------
module mec_core #(
	parameter int MAX_ITERATIONS = 64,
	parameter int FRAC_BITS      = 28,
	localparam int CW       = $clog2(MAX_ITERATIONS + 1),
	localparam int BAND_LEN = MAX_ITERATIONS / mec_pkg::BAND_COUNT,
	localparam int KW       = (BAND_LEN > 1) ? $clog2(BAND_LEN) : 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	mec_point_if.sink                   point,
	output logic                        fin_valid,
	input  logic                        fin_take,
	output logic [CW-1:0]               fin_count,
	output logic [mec_pkg::BAND_W-1:0]  fin_band,
	output logic [KW-1:0]               fin_k
);

	localparam int ZW = ((FRAC_BITS + 2 > 30) ? FRAC_BITS + 2 : 30) + 2;
	localparam int PW = 2 * ZW;
	localparam int LIM_BIT = 2 * FRAC_BITS + 2;

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_RR   = 6'b000010,
		S_II   = 6'b000100,
		S_RI   = 6'b001000,
		S_UPD  = 6'b010000,
		S_FIN  = 6'b100000
	} state_t;

	state_t state_q;
	logic [CW-1:0] count_q;
	logic [mec_pkg::BAND_W-1:0] band_q;
	logic [KW-1:0] k_q;

	logic signed [ZW-1:0] re_q, im_q, cre_q, cim_q;
	logic signed [PW-1:0] rr_q, diff_q;
	logic esc_q;

	logic signed [ZW-1:0] mul_a, mul_b;
	logic signed [PW-1:0] mul_prod;
	logic [PW-1:0] mag_sum;
	logic signed [PW-1:0] re_sh, im_sh;

	assign mul_a = (state_q == S_II) ? im_q : re_q;
	assign mul_b = (state_q == S_RR) ? re_q : im_q;

	mec_mul #(.W(ZW)) u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.prod (mul_prod)
	);

	// squares are nonnegative, so the sum is plain unsigned
	assign mag_sum = rr_q + mul_prod;
	assign re_sh   = diff_q >>> FRAC_BITS;
	assign im_sh   = mul_prod >>> (FRAC_BITS - 1);

	// sequencer and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			band_q  <= mec_pkg::BAND_PURPLE;
			k_q     <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (point.valid) begin
						count_q <= '0;
						band_q  <= mec_pkg::BAND_PURPLE;
						k_q     <= '0;
						state_q <= S_RR;
					end
				end
				S_RR: state_q <= S_II;
				S_II: state_q <= S_RI;
				S_RI: state_q <= S_UPD;
				S_UPD: begin
					if (esc_q) begin
						state_q <= S_FIN;
					end else begin
						count_q <= count_q + CW'(1);
						if (k_q == KW'(BAND_LEN - 1)) begin
							k_q <= '0;
							if (band_q != mec_pkg::BAND_RED) begin
								band_q <= band_q + mec_pkg::BAND_W'(1);
							end
						end else begin
							k_q <= k_q + KW'(1);
						end
						if (count_q == CW'(MAX_ITERATIONS - 1)) begin
							state_q <= S_FIN;
						end else begin
							state_q <= S_RR;
						end
					end
				end
				S_FIN: begin
					if (fin_take) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && point.valid) begin
			cre_q <= ZW'(point.point_re);
			cim_q <= ZW'(point.point_im);
			re_q  <= '0;
			im_q  <= '0;
		end
		if (state_q == S_II) begin
			rr_q <= mul_prod;
		end
		if (state_q == S_RI) begin
			esc_q  <= |mag_sum[PW-1:LIM_BIT];
			diff_q <= rr_q - mul_prod;
		end
		if (state_q == S_UPD && !esc_q) begin
			re_q <= re_sh[ZW-1:0] + cre_q;
			im_q <= im_sh[ZW-1:0] + cim_q;
		end
	end

	assign point.ready = (state_q == S_IDLE);
	assign fin_valid   = (state_q == S_FIN);
	assign fin_count   = count_q;
	assign fin_band    = band_q;
	assign fin_k       = k_q;

endmodule

FILE: hdl/mec_color.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mec_color
// Maps the iteration count, band and offset within the band to RGB.
// ----------------------------------------------------------------------------
module mec_color #(
	parameter int MAX_ITERATIONS = 64,
	localparam int CW       = $clog2(MAX_ITERATIONS + 1),
	localparam int BAND_LEN = MAX_ITERATIONS / mec_pkg::BAND_COUNT,
	localparam int KW       = (BAND_LEN > 1) ? $clog2(BAND_LEN) : 1
) (
	input  logic [CW-1:0]              count,
	input  logic [mec_pkg::BAND_W-1:0] band,
	input  logic [KW-1:0]              k,
	output mec_pkg::rgb_t              rgb
);

	localparam int STEP_LO = mec_pkg::LEVEL_STEP / BAND_LEN;
	localparam int STEP_HI = mec_pkg::LEVEL_SPAN / BAND_LEN;

	logic [KW+7:0] lo_w, hi_w;
	logic [mec_pkg::CHAN_W-1:0] ramp_lo, ramp_hi;

	assign lo_w    = (KW + 8)'(k) * (KW + 8)'(STEP_LO);
	assign hi_w    = (KW + 8)'(k) * (KW + 8)'(STEP_HI);
	assign ramp_lo = lo_w[mec_pkg::CHAN_W-1:0];
	assign ramp_hi = hi_w[mec_pkg::CHAN_W-1:0];

	always_comb begin
		rgb.red   = mec_pkg::LEVEL_ZERO;
		rgb.green = mec_pkg::LEVEL_ZERO;
		rgb.blue  = mec_pkg::LEVEL_ZERO;
		if (count != CW'(MAX_ITERATIONS)) begin
			unique case (band)
				mec_pkg::BAND_PURPLE: begin
					rgb.red  = mec_pkg::LEVEL_MID;
					rgb.blue = mec_pkg::LEVEL_MID + ramp_lo;
				end
				mec_pkg::BAND_BLUE: begin
					rgb.blue = mec_pkg::LEVEL_MID + ramp_lo;
				end
				mec_pkg::BAND_GREEN: begin
					rgb.green = mec_pkg::LEVEL_MID + ramp_lo;
				end
				mec_pkg::BAND_FADE: begin
					rgb.red   = mec_pkg::LEVEL_FULL - ramp_lo;
					rgb.green = mec_pkg::LEVEL_FULL - ramp_hi;
				end
				default: begin
					rgb.red = mec_pkg::LEVEL_FULL;
				end
			endcase
		end
	end

endmodule

FILE: hdl/mandelbrot_escape_color.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mandelbrot_escape_color
// Escape-time count of z = z*z + c with five-band coloring.
//
//   channel  dir  fields
//   point    in   point_re, point_im   (signed, FRAC_BITS fraction bits)
//   pixel    out  iter_count, red, green, blue
//
// one point at a time; each iteration steps through S_RR, S_II, S_RI and
// S_UPD on the single shared multiplier (re*re, im*im, re*im, then update)
// the core holds its result in S_FIN until the result register takes it,
// then returns to idle and can accept the next point
// point.ready is high only while idle; the result register frees the core
// as soon as the previous pixel is taken
// asynchronous reset clears the sequencer and the result valid
// ----------------------------------------------------------------------------
module mandelbrot_escape_color #(
	parameter int MAX_ITERATIONS = 64,
	parameter int FRAC_BITS      = 28
) (
	input  logic         clk,
	input  logic         arst_n,
	mec_point_if.sink    point,
	mec_pixel_if.source  pixel
);

	localparam int CW       = $clog2(MAX_ITERATIONS + 1);
	localparam int BAND_LEN = MAX_ITERATIONS / mec_pkg::BAND_COUNT;
	localparam int KW       = (BAND_LEN > 1) ? $clog2(BAND_LEN) : 1;

	logic fin_valid, fin_take;
	logic [CW-1:0] fin_count;
	logic [mec_pkg::BAND_W-1:0] fin_band;
	logic [KW-1:0] fin_k;
	mec_pkg::rgb_t fin_rgb;
	logic [CW+mec_pkg::COUNT_OUT_W-1:0] count_ext;

	logic out_valid_q;
	logic [mec_pkg::COUNT_OUT_W-1:0] count_q;
	mec_pkg::rgb_t rgb_q;

	mec_core #(
		.MAX_ITERATIONS (MAX_ITERATIONS),
		.FRAC_BITS      (FRAC_BITS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.point     (point),
		.fin_valid (fin_valid),
		.fin_take  (fin_take),
		.fin_count (fin_count),
		.fin_band  (fin_band),
		.fin_k     (fin_k)
	);

	mec_color #(
		.MAX_ITERATIONS (MAX_ITERATIONS)
	) u_color (
		.count (fin_count),
		.band  (fin_band),
		.k     (fin_k),
		.rgb   (fin_rgb)
	);

	assign fin_take  = fin_valid && (!out_valid_q || pixel.ready);
	assign count_ext = {{mec_pkg::COUNT_OUT_W{1'b0}}, fin_count};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin_take) begin
			out_valid_q <= 1'b1;
		end else if (pixel.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_take) begin
			count_q <= count_ext[mec_pkg::COUNT_OUT_W-1:0];
			rgb_q   <= fin_rgb;
		end
	end

	assign pixel.valid      = out_valid_q;
	assign pixel.iter_count = count_q;
	assign pixel.red        = rgb_q.red;
	assign pixel.green      = rgb_q.green;
	assign pixel.blue       = rgb_q.blue;

	a_take_loads: assert property (@(posedge clk) disable iff (!arst_n)
		fin_take |=> pixel.valid)
		else $error("finished result not presented");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(point.valid && point.ready) |=> !point.ready)
		else $error("core ready while a point is in work");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(pixel.valid && !pixel.ready) |-> !fin_take)
		else $error("pending pixel overwritten");

	a_black_at_max: assert property (@(posedge clk) disable iff (!arst_n)
		(fin_take && fin_count == CW'(MAX_ITERATIONS)) |=>
		(pixel.red == mec_pkg::LEVEL_ZERO && pixel.green == mec_pkg::LEVEL_ZERO &&
		 pixel.blue == mec_pkg::LEVEL_ZERO))
		else $error("bounded point not black");

endmodule

FILE: bench/mec_pixel_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mec_pixel_checker
// Watches the point and pixel channels of the escape-time colorer. Every
// accepted point is run through an independent fixed-point escape-time
// calculation and band coloring, and the expected pixel is queued. Every
// accepted pixel is compared field by field with the oldest queued one.
// ----------------------------------------------------------------------------
module mec_pixel_checker #(
	parameter int MAX_ITERATIONS = 64,
	parameter int FRAC_BITS      = 28
) (
	input  logic   clk,
	input  logic   arst_n,
	mec_point_if   point,
	mec_pixel_if   pixel,
	output int     mismatches,
	output int     outstanding
);

	typedef struct packed {
		logic [mec_pkg::COUNT_OUT_W-1:0] iter_count;
		mec_pkg::rgb_t color;
	} pixel_t;

	pixel_t pending_pixels[$];

	function automatic pixel_t predict_escape_pixel(
			input logic signed [mec_pkg::POINT_W-1:0] c_re,
			input logic signed [mec_pkg::POINT_W-1:0] c_im);
		logic signed [63:0] z_re, z_im, add_re, add_im;
		logic signed [127:0] w_re, w_im, sq_re, sq_im, prod_ri, scaled, bound;
		int count, width, band, k;
		pixel_t px;
		add_re = c_re;
		add_im = c_im;
		z_re = '0;
		z_im = '0;
		count = 0;
		bound = 128'sd4 << (2 * FRAC_BITS);
		while (1) begin
			w_re = z_re;
			w_im = z_im;
			sq_re = w_re * w_re;
			sq_im = w_im * w_im;
			prod_ri = w_re * w_im;
			if (sq_re + sq_im >= bound)
				break;
			// floor division by 2^FRAC_BITS on exact products
			scaled = (sq_re - sq_im) >>> FRAC_BITS;
			z_re = scaled[63:0] + add_re;
			scaled = (prod_ri <<< 1) >>> FRAC_BITS;
			z_im = scaled[63:0] + add_im;
			count++;
			if (count == MAX_ITERATIONS)
				break;
		end
		width = MAX_ITERATIONS / mec_pkg::BAND_COUNT;
		band = count / width;
		k = count % width;
		px.iter_count = mec_pkg::COUNT_OUT_W'(count);
		px.color.red = mec_pkg::LEVEL_ZERO;
		px.color.green = mec_pkg::LEVEL_ZERO;
		px.color.blue = mec_pkg::LEVEL_ZERO;
		if (count != MAX_ITERATIONS) begin
			case (band)
				int'(mec_pkg::BAND_PURPLE): begin
					px.color.red = mec_pkg::LEVEL_MID;
					px.color.blue = mec_pkg::CHAN_W'(int'(mec_pkg::LEVEL_MID) +
						k * (mec_pkg::LEVEL_STEP / width));
				end
				int'(mec_pkg::BAND_BLUE): begin
					px.color.blue = mec_pkg::CHAN_W'(int'(mec_pkg::LEVEL_MID) +
						k * (mec_pkg::LEVEL_STEP / width));
				end
				int'(mec_pkg::BAND_GREEN): begin
					px.color.green = mec_pkg::CHAN_W'(int'(mec_pkg::LEVEL_MID) +
						k * (mec_pkg::LEVEL_STEP / width));
				end
				int'(mec_pkg::BAND_FADE): begin
					px.color.red = mec_pkg::CHAN_W'(int'(mec_pkg::LEVEL_FULL) -
						k * (mec_pkg::LEVEL_STEP / width));
					px.color.green = mec_pkg::CHAN_W'(int'(mec_pkg::LEVEL_FULL) -
						k * (mec_pkg::LEVEL_SPAN / width));
				end
				default: begin
					px.color.red = mec_pkg::LEVEL_FULL;
				end
			endcase
		end
		return px;
	endfunction

	always @(posedge clk) begin
		pixel_t exp_px;
		if (!arst_n) begin
			pending_pixels.delete();
			mismatches = 0;
			outstanding = 0;
		end else begin
			if (point.valid && point.ready)
				pending_pixels.push_back(predict_escape_pixel(point.point_re, point.point_im));
			if (pixel.valid && pixel.ready) begin
				if (pending_pixels.size() == 0) begin
					$error("pixel transfer with no point pending");
					mismatches++;
				end else begin
					exp_px = pending_pixels.pop_front();
					if (pixel.iter_count !== exp_px.iter_count) begin
						$error("iter_count expected %0d actual %0d", exp_px.iter_count,
							pixel.iter_count);
						mismatches++;
					end
					if (pixel.red !== exp_px.color.red) begin
						$error("red expected %0d actual %0d", exp_px.color.red, pixel.red);
						mismatches++;
					end
					if (pixel.green !== exp_px.color.green) begin
						$error("green expected %0d actual %0d", exp_px.color.green, pixel.green);
						mismatches++;
					end
					if (pixel.blue !== exp_px.color.blue) begin
						$error("blue expected %0d actual %0d", exp_px.color.blue, pixel.blue);
						mismatches++;
					end
				end
			end
			outstanding = pending_pixels.size();
		end
	end

endmodule

FILE: bench/mandelbrot_escape_color_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mandelbrot_escape_color_tb
// Drives complex points into the escape-time colorer: a directed set of
// field extremes and set-boundary points, then random points mixed from the
// full field range, the main view, the cusp of the cardioid and the neck
// between bulbs. Sender gaps and receiver stalls change phase by phase; the
// checker beside the block predicts and compares every pixel.
// ----------------------------------------------------------------------------
module mandelbrot_escape_color_tb;

	localparam int ITER_LIMIT   = 64;
	localparam int FRAC         = 28;
	localparam int ONE          = 1 << FRAC;
	localparam int PHASE_ITEMS  = 295;
	localparam int DRAIN_CYCLES = 300;
	localparam int CYCLE_LIMIT  = 3_000_000;

	localparam logic signed [mec_pkg::POINT_W-1:0] FIELD_MIN =
		{1'b1, {(mec_pkg::POINT_W-1){1'b0}}};
	localparam logic signed [mec_pkg::POINT_W-1:0] FIELD_MAX =
		{1'b0, {(mec_pkg::POINT_W-1){1'b1}}};

	logic clk = 1'b0;
	logic arst_n;
	int send_idle_pct;
	int recv_stall_pct;
	int mismatches;
	int outstanding;
	int cycle_count;

	mec_point_if point_ch ();
	mec_pixel_if pixel_ch ();

	mandelbrot_escape_color #(
		.MAX_ITERATIONS(ITER_LIMIT),
		.FRAC_BITS(FRAC)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.point(point_ch),
		.pixel(pixel_ch)
	);

	mec_pixel_checker #(
		.MAX_ITERATIONS(ITER_LIMIT),
		.FRAC_BITS(FRAC)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.point(point_ch),
		.pixel(pixel_ch),
		.mismatches(mismatches),
		.outstanding(outstanding)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		pixel_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	function automatic logic signed [mec_pkg::POINT_W-1:0] pick(input int lo, input int span);
		return mec_pkg::POINT_W'(lo + int'($urandom_range(span)));
	endfunction

	task automatic send_point(input logic signed [mec_pkg::POINT_W-1:0] re,
			input logic signed [mec_pkg::POINT_W-1:0] im);
		if ($urandom_range(99) < send_idle_pct) begin
			point_ch.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		point_ch.valid <= 1'b1;
		point_ch.point_re <= re;
		point_ch.point_im <= im;
		do @(posedge clk); while (!point_ch.ready);
	endtask

	task automatic send_random_point();
		int kind;
		kind = $urandom_range(99);
		if (kind < 15)
			send_point(mec_pkg::POINT_W'($urandom), mec_pkg::POINT_W'($urandom));
		else if (kind < 60)
			send_point(pick(-(ONE / 4) * 9, ONE * 3), pick(-(ONE * 3) / 2, ONE * 3));
		else if (kind < 80)
			send_point(pick(ONE / 4, ONE / 100), pick(-ONE / 128, ONE / 64));
		else
			send_point(mec_pkg::POINT_W'(-(ONE * 3) / 4), pick(-ONE / 10, ONE / 5));
	endtask

	initial begin
		arst_n = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		point_ch.valid <= 1'b0;
		point_ch.point_re <= '0;
		point_ch.point_im <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// field extremes and points on or near the set boundary
		send_point(FIELD_MIN, FIELD_MIN);
		send_point(FIELD_MAX, FIELD_MAX);
		send_point(FIELD_MIN, FIELD_MAX);
		send_point(FIELD_MAX, FIELD_MIN);
		send_point('0, '0);
		send_point(mec_pkg::POINT_W'(-2 * ONE), '0);
		send_point(mec_pkg::POINT_W'(2 * ONE), '0);
		send_point('0, mec_pkg::POINT_W'(2 * ONE));
		send_point('0, mec_pkg::POINT_W'(-2 * ONE));
		send_point(mec_pkg::POINT_W'(ONE / 4), '0);
		send_point(mec_pkg::POINT_W'(ONE / 4 + ONE / 512), '0);
		send_point(mec_pkg::POINT_W'(ONE / 4 + ONE / 300), '0);
		send_point(mec_pkg::POINT_W'(ONE / 4 + ONE / 100), '0);
		send_point(mec_pkg::POINT_W'(-ONE), '0);
		send_point(mec_pkg::POINT_W'(ONE), '0);
		send_point('0, mec_pkg::POINT_W'(ONE));
		send_point(mec_pkg::POINT_W'(-(ONE * 3) / 4), mec_pkg::POINT_W'(ONE / 16));
		send_point(mec_pkg::POINT_W'(-(ONE * 3) / 4), mec_pkg::POINT_W'(-ONE / 40));
		send_point(mec_pkg::POINT_W'((ONE * 3) / 10), mec_pkg::POINT_W'(ONE / 2));
		send_point(mec_pkg::POINT_W'(-1), mec_pkg::POINT_W'(1));

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 79;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 79;
				end
				default: begin
					send_idle_pct = 36;
					recv_stall_pct = 36;
				end
			endcase
			repeat (PHASE_ITEMS) send_random_point();
		end

		point_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb: failure");
		$finish;
	end

endmodule
